// ===== design/stt_pkg.sv =====
// Shared types, constants and helper functions of the source text tokenizer.
`default_nettype none
package stt_pkg;

  localparam int KW_MAX_CHARS = 8;
  localparam int KW_COUNT = 16;
  localparam int RES_PER_ITEM = 3;
  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    M_IDLE  = 3'd0,
    M_IDENT = 3'd1,
    M_INT   = 3'd2,
    M_FRAC  = 3'd3,
    M_STR   = 3'd4,
    M_ESC   = 3'd5,
    M_PEND  = 3'd6
  } lex_mode_e;

  typedef enum logic [1:0] {
    P_EQ   = 2'd0,
    P_BANG = 2'd1,
    P_LT   = 2'd2,
    P_GT   = 2'd3
  } pend_sym_e;

  localparam logic [1:0] REC_BYTE = 2'd0;
  localparam logic [1:0] REC_END  = 2'd1;
  localparam logic [1:0] REC_EOT  = 2'd2;
  localparam logic [1:0] REC_ERR  = 2'd3;

  localparam logic [5:0] K_NONE   = 6'd0;
  localparam logic [5:0] K_IDENT  = 6'd1;
  localparam logic [5:0] K_NUMBER = 6'd2;
  localparam logic [5:0] K_STRING = 6'd3;
  localparam logic [5:0] K_EQEQ   = 6'd19;
  localparam logic [5:0] K_NEQ    = 6'd20;
  localparam logic [5:0] K_LE     = 6'd21;
  localparam logic [5:0] K_GE     = 6'd22;
  localparam logic [5:0] K_ASSIGN = 6'd36;
  localparam logic [5:0] K_GT     = 6'd37;
  localparam logic [5:0] K_LT     = 6'd38;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_LOW_N  = 8'h6e;
  localparam logic [7:0] CH_LOW_T  = 8'h74;

  localparam logic [15:0] LEN_MAX = 16'hFFFF;
  localparam logic [23:0] OFF_MAX = 24'hFFFFFF;

  // keyword text, first character in the low byte
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    64'h6669, 64'h65736c65, 64'h656c696877, 64'h6e66,
    64'h6e7275746572, 64'h65756e69746e6f63, 64'h7478656e, 64'h6b61657262,
    64'h746e69, 64'h676e6f6c, 64'h74616f6c66, 64'h656c62756f64,
    64'h6c6f6f62, 64'h676e69727473, 64'h65757274, 64'h65736c6166
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd2, 4'd4, 4'd5, 4'd2, 4'd6, 4'd8, 4'd4, 4'd5,
    4'd3, 4'd4, 4'd5, 4'd6, 4'd4, 4'd6, 4'd4, 4'd5
  };
  localparam logic [5:0] KW_KIND [KW_COUNT] = '{
    6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd9, 6'd10,
    6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18
  };

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [7:0]  char_value;
    logic [5:0]  token_kind;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [23:0] start_offset;
    logic [15:0] token_length;
    logic        last_of_run;
  } rec_t;

  typedef struct packed {
    logic [1:0]                  cnt;
    rec_t [RES_PER_ITEM-1:0]     rec;
  } push_t;

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic logic is_suffix(input logic [7:0] b);
    return b == 8'h4c || b == 8'h6c || b == 8'h46 || b == 8'h66 ||
           b == 8'h44 || b == 8'h64;
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] b);
    logic [5:0] k;
    unique case (b)
      8'h2d:   k = 6'd23;
      8'h2b:   k = 6'd24;
      8'h2a:   k = 6'd25;
      8'h2f:   k = 6'd26;
      8'h25:   k = 6'd27;
      8'h26:   k = 6'd28;
      8'h7c:   k = 6'd29;
      8'h28:   k = 6'd30;
      8'h29:   k = 6'd31;
      8'h7b:   k = 6'd32;
      8'h7d:   k = 6'd33;
      8'h40:   k = 6'd34;
      8'h2c:   k = 6'd35;
      8'h3a:   k = 6'd39;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  // match the first keyword characters against the keyword list
  function automatic logic [5:0] kw_kind(input logic [63:0] w, input logic [15:0] len);
    logic [5:0]  k;
    logic [63:0] mask;
    k = K_IDENT;
    for (int i = 0; i < KW_COUNT; i++) begin
      mask = ~(64'hFFFF_FFFF_FFFF_FFFF << (8 * int'(KW_LEN[i])));
      if (len == 16'(KW_LEN[i]) && ((w ^ KW_TEXT[i]) & mask) == 64'd0) begin
        k = KW_KIND[i];
      end
    end
    return k;
  endfunction

  function automatic rec_t byte_rec(input logic [7:0] ch);
    rec_t r;
    r = '0;
    r.record_kind = REC_BYTE;
    r.char_value = ch;
    return r;
  endfunction

  function automatic rec_t pos_rec(input logic [1:0] kind, input logic [7:0] ch,
                                   input logic [5:0] tk, input logic [15:0] ln,
                                   input logic [15:0] col, input logic [23:0] off,
                                   input logic [15:0] len);
    rec_t r;
    r.record_kind = kind;
    r.char_value = ch;
    r.token_kind = tk;
    r.start_line = ln;
    r.start_column = col;
    r.start_offset = off;
    r.token_length = len;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  function automatic logic [15:0] sat_inc16(input logic [15:0] v, input logic [15:0] mx);
    return (v >= mx) ? mx : v + 16'd1;
  endfunction

endpackage
`default_nettype wire

// ===== design/stt_byte_if.sv =====
// Handshake channel carrying one source text byte.
`default_nettype none
interface stt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface
`default_nettype wire

// ===== design/stt_rec_if.sv =====
// Handshake channel carrying one tokenizer result record.
`default_nettype none
interface stt_rec_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [7:0]  char_value;
  logic [5:0]  token_kind;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic [23:0] start_offset;
  logic [15:0] token_length;
  logic        last_of_run;

  modport source (output valid, output record_kind, output char_value, output token_kind,
                  output start_line, output start_column, output start_offset,
                  output token_length, output last_of_run, input ready);
  modport sink (input valid, input record_kind, input char_value, input token_kind,
                input start_line, input start_column, input start_offset,
                input token_length, input last_of_run, output ready);
endinterface
`default_nettype wire

// ===== design/stt_lexer.sv =====
// Input byte register and the single-pass lexer step that makes up to three records.
`default_nettype none
module stt_lexer #(
  parameter int KEYWORD_CHARS = 8,
  parameter int POSITION_BITS = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  stt_byte_if.sink      text_i,
  input  wire logic     space_i,
  output stt_pkg::push_t push_o
);
  import stt_pkg::*;

  localparam int IW = $clog2(KEYWORD_CHARS);
  localparam logic [15:0] POS_MAX =
    (POSITION_BITS >= 16) ? 16'hFFFF : 16'((1 << POSITION_BITS) - 1);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       fire;

  lex_mode_e  mode_q, mode_d;
  logic       qs_q, qs_d;
  pend_sym_e  pend_q, pend_d;
  logic [KEYWORD_CHARS-1:0][7:0] wbuf_q, wbuf_d;
  logic [15:0] cur_line_q, cur_line_d, cur_col_q, cur_col_d;
  logic [23:0] cur_off_q, cur_off_d;
  logic [15:0] tln_q, tln_d, tcol_q, tcol_d, tlen_q, tlen_d;
  logic [23:0] toff_q, toff_d;

  rec_t [RES_PER_ITEM-1:0] res;
  logic [1:0] n;
  logic       used, do_str;
  logic [7:0] b, qch;
  logic [5:0] sk;

  assign fire = valid_q && space_i;
  assign text_i.ready = !valid_q || space_i;
  assign valid_d = (text_i.valid && text_i.ready) ? 1'b1 : (fire ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      mode_q     <= M_IDLE;
      qs_q       <= 1'b0;
      pend_q     <= P_EQ;
      wbuf_q     <= '0;
      cur_line_q <= 16'd1;
      cur_col_q  <= 16'd1;
      cur_off_q  <= '0;
      tln_q      <= 16'd1;
      tcol_q     <= 16'd1;
      toff_q     <= '0;
      tlen_q     <= '0;
    end else begin
      valid_q    <= valid_d;
      mode_q     <= mode_d;
      qs_q       <= qs_d;
      pend_q     <= pend_d;
      wbuf_q     <= wbuf_d;
      cur_line_q <= cur_line_d;
      cur_col_q  <= cur_col_d;
      cur_off_q  <= cur_off_d;
      tln_q      <= tln_d;
      tcol_q     <= tcol_d;
      toff_q     <= toff_d;
      tlen_q     <= tlen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_i.valid && text_i.ready) begin
      byte_q <= text_i.text_byte;
    end
  end

  always_comb begin
    mode_d = mode_q;
    qs_d   = qs_q;
    pend_d = pend_q;
    wbuf_d = wbuf_q;
    tln_d  = tln_q;
    tcol_d = tcol_q;
    toff_d = toff_q;
    tlen_d = tlen_q;
    cur_line_d = cur_line_q;
    cur_col_d  = cur_col_q;
    cur_off_d  = cur_off_q;
    res    = '0;
    n      = 2'd0;
    used   = 1'b0;
    do_str = 1'b0;
    b      = byte_q;
    qch    = qs_q ? CH_SQUOTE : CH_DQUOTE;
    sk     = single_kind(byte_q);

    if (fire) begin
      unique case (mode_q)
        M_IDENT: begin
          if (is_alpha(b) || is_digit(b) || b == CH_UNDER) begin
            if (tlen_d < 16'(KEYWORD_CHARS)) wbuf_d[tlen_d[IW-1:0]] = b;
            res[n] = byte_rec(b); n = n + 2'd1;
            tlen_d = sat_inc16(tlen_d, LEN_MAX);
            used = 1'b1;
          end else begin
            res[n] = pos_rec(REC_END, CH_NUL, kw_kind(wbuf_q[KW_MAX_CHARS-1:0], tlen_d),
                             tln_d, tcol_d, toff_d, tlen_d);
            n = n + 2'd1;
            mode_d = M_IDLE;
          end
        end
        M_INT, M_FRAC: begin
          if (is_digit(b) || (b == CH_DOT && mode_q == M_INT)) begin
            res[n] = byte_rec(b); n = n + 2'd1;
            tlen_d = sat_inc16(tlen_d, LEN_MAX);
            if (b == CH_DOT) mode_d = M_FRAC;
            used = 1'b1;
          end else if (is_suffix(b)) begin
            res[n] = byte_rec(b); n = n + 2'd1;
            tlen_d = sat_inc16(tlen_d, LEN_MAX);
            res[n] = pos_rec(REC_END, CH_NUL, K_NUMBER, tln_d, tcol_d, toff_d, tlen_d);
            n = n + 2'd1;
            mode_d = M_IDLE;
            used = 1'b1;
          end else begin
            res[n] = pos_rec(REC_END, CH_NUL, K_NUMBER, tln_d, tcol_d, toff_d, tlen_d);
            n = n + 2'd1;
            mode_d = M_IDLE;
          end
        end
        M_STR: do_str = 1'b1;
        M_ESC: begin
          mode_d = M_STR;
          priority if (b == CH_LOW_N) begin
            res[n] = byte_rec(CH_NL); n = n + 2'd1; used = 1'b1;
          end else if (b == CH_LOW_T) begin
            res[n] = byte_rec(CH_TAB); n = n + 2'd1; used = 1'b1;
          end else if (b == CH_BSLASH) begin
            res[n] = byte_rec(CH_BSLASH); n = n + 2'd1; used = 1'b1;
          end else if (b == qch) begin
            res[n] = byte_rec(qch); n = n + 2'd1; used = 1'b1;
          end else begin
            // unknown escape: keep the backslash, then treat the byte as content
            res[n] = byte_rec(CH_BSLASH); n = n + 2'd1;
            do_str = 1'b1;
          end
          if (used || do_str) tlen_d = sat_inc16(tlen_d, LEN_MAX);
        end
        M_PEND: begin
          mode_d = M_IDLE;
          if (b == CH_EQ) begin
            if (pend_q == P_BANG) begin
              res[n] = byte_rec(CH_BANG); n = n + 2'd1;
              tlen_d = sat_inc16(tlen_d, LEN_MAX);
            end
            res[n] = byte_rec(CH_EQ); n = n + 2'd1;
            tlen_d = sat_inc16(tlen_d, LEN_MAX);
            unique case (pend_q)
              P_EQ:    sk = K_EQEQ;
              P_BANG:  sk = K_NEQ;
              P_LT:    sk = K_LE;
              default: sk = K_GE;
            endcase
            res[n] = pos_rec(REC_END, CH_NUL, sk, tln_d, tcol_d, toff_d, tlen_d);
            n = n + 2'd1;
            used = 1'b1;
          end else if (pend_q == P_BANG) begin
            res[n] = pos_rec(REC_ERR, CH_BANG, K_NONE, tln_d, tcol_d, toff_d, 16'd0);
            n = n + 2'd1;
          end else begin
            res[n] = pos_rec(REC_END, CH_NUL,
                             (pend_q == P_EQ) ? K_ASSIGN : ((pend_q == P_LT) ? K_LT : K_GT),
                             tln_d, tcol_d, toff_d, tlen_d);
            n = n + 2'd1;
          end
        end
        default: mode_d = M_IDLE;
      endcase

      if (do_str) begin
        priority if (b == qch) begin
          res[n] = pos_rec(REC_END, CH_NUL, K_STRING, tln_d, tcol_d, toff_d, tlen_d);
          n = n + 2'd1; mode_d = M_IDLE; used = 1'b1;
        end else if (b == CH_NUL) begin
          res[n] = pos_rec(REC_END, CH_NUL, K_STRING, tln_d, tcol_d, toff_d, tlen_d);
          n = n + 2'd1; mode_d = M_IDLE;
        end else if (b == CH_BSLASH) begin
          mode_d = M_ESC; used = 1'b1;
        end else begin
          res[n] = byte_rec(b); n = n + 2'd1;
          tlen_d = sat_inc16(tlen_d, LEN_MAX);
          used = 1'b1;
        end
      end

      // start a new token with a byte that the current one did not take
      if (!used) begin
        priority if (b == CH_NUL) begin
          res[n] = pos_rec(REC_EOT, CH_NUL, K_NONE, cur_line_q, cur_col_q, cur_off_q, 16'd0);
          n = n + 2'd1; mode_d = M_IDLE;
        end else if (is_space(b)) begin
        end else begin
          tln_d = cur_line_q; tcol_d = cur_col_q; toff_d = cur_off_q; tlen_d = 16'd0;
          priority if (is_alpha(b) || b == CH_UNDER) begin
            mode_d = M_IDENT;
            wbuf_d[0] = b;
            res[n] = byte_rec(b); n = n + 2'd1; tlen_d = 16'd1;
          end else if (is_digit(b)) begin
            mode_d = M_INT;
            res[n] = byte_rec(b); n = n + 2'd1; tlen_d = 16'd1;
          end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
            mode_d = M_STR;
            qs_d = (b == CH_SQUOTE);
          end else if (b == CH_EQ || b == CH_BANG || b == CH_LT || b == CH_GT) begin
            mode_d = M_PEND;
            pend_d = (b == CH_EQ) ? P_EQ : (b == CH_BANG) ? P_BANG : (b == CH_LT) ? P_LT : P_GT;
            if (b != CH_BANG) begin
              res[n] = byte_rec(b); n = n + 2'd1; tlen_d = 16'd1;
            end
          end else if (single_kind(b) != K_NONE) begin
            res[n] = byte_rec(b); n = n + 2'd1; tlen_d = 16'd1;
            res[n] = pos_rec(REC_END, CH_NUL, single_kind(b), tln_d, tcol_d, toff_d, tlen_d);
            n = n + 2'd1;
          end else begin
            res[n] = pos_rec(REC_ERR, b, K_NONE, tln_d, tcol_d, toff_d, 16'd0);
            n = n + 2'd1;
          end
        end
      end

      // advance the position; end of text restarts it
      if (b == CH_NUL) begin
        cur_line_d = 16'd1;
        cur_col_d  = 16'd1;
        cur_off_d  = '0;
      end else begin
        if (b == CH_NL) begin
          cur_line_d = sat_inc16(cur_line_q, POS_MAX);
          cur_col_d  = 16'd1;
        end else begin
          cur_col_d = sat_inc16(cur_col_q, POS_MAX);
        end
        cur_off_d = (cur_off_q == OFF_MAX) ? OFF_MAX : cur_off_q + 24'd1;
      end
    end

    for (int i = 0; i < RES_PER_ITEM; i++) begin
      res[i].last_of_run = (2'(i) == 2'(n - 2'd1));
    end
  end

  assign push_o.cnt = n;
  assign push_o.rec = res;

`ifndef SYNTHESIS
  a_eot_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && byte_q == CH_NUL |=> cur_line_q == 16'd1 && cur_col_q == 16'd1 && cur_off_q == '0)
    else $error("position not restarted after end of text");
  a_esc_from_str: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && mode_d == M_ESC |-> mode_q == M_STR || mode_q == M_ESC)
    else $error("escape entered outside a string");
  a_push_needs_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.cnt != 2'd0 |-> fire)
    else $error("records pushed without an item");
`endif

endmodule
`default_nettype wire

// ===== design/stt_res_fifo.sv =====
// Result queue taking up to three records per cycle and giving one per cycle while rec_o.ready is high.
`default_nettype none
module stt_res_fifo (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  stt_pkg::push_t  push_i,
  output logic            space_o,
  stt_rec_if.source       rec_o
);
  import stt_pkg::*;

  rec_t mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_q, rp_q;
  logic [QPTR_W:0]   count_q;
  logic              pop;
  rec_t              head;

  assign space_o = count_q <= (QPTR_W+1)'(QUEUE_DEPTH - RES_PER_ITEM);
  assign pop = rec_o.valid && rec_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      wp_q    <= wp_q + QPTR_W'(push_i.cnt);
      rp_q    <= rp_q + QPTR_W'(pop);
      count_q <= count_q + (QPTR_W+1)'(push_i.cnt) - (QPTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < RES_PER_ITEM; i++) begin
      if (2'(i) < push_i.cnt) begin
        mem_q[wp_q + QPTR_W'(i)] <= push_i.rec[i];
      end
    end
  end

  assign head = mem_q[rp_q];
  assign rec_o.valid        = count_q != '0;
  assign rec_o.record_kind  = head.record_kind;
  assign rec_o.char_value   = head.char_value;
  assign rec_o.token_kind   = head.token_kind;
  assign rec_o.start_line   = head.start_line;
  assign rec_o.start_column = head.start_column;
  assign rec_o.start_offset = head.start_offset;
  assign rec_o.token_length = head.token_length;
  assign rec_o.last_of_run  = head.last_of_run;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("result queue overflow");
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.cnt != 2'd0 |-> space_o)
    else $error("records pushed into a full queue");
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && push_i.cnt == 2'd0 |=> count_q == $past(count_q) - 1'b1)
    else $error("queue count lost a pop");
`endif

endmodule
`default_nettype wire

// ===== design/source_text_tokenizer.sv =====
// Top level of the source text tokenizer: lexer step feeding a result queue.
//
// Usage: source bytes enter on text_i (valid/ready), one byte per item, byte 0
// marking end of text. Records leave on rec_o (valid/ready): token text bytes,
// a token end record with kind and start position, end-of-text and error records.
// last_of_run marks the final record caused by one input byte.
// Path: an accepted byte is held in the input register, lexed once the queue has
// room, and its records are written into the queue before rec_o offers them.
// Throughput: one byte per cycle while the receiver keeps up; each byte makes
// zero to three records, and rec_o gives one record per cycle from an
// eight-entry queue, so the output port sets the sustained rate when bytes
// produce more than one record each.
// Stall: the lexer step waits whenever the queue has fewer than three free
// entries; text_i.ready then drops once the input register is full.
// Reset: position returns to line 1, column 1, offset 0, the lexer goes idle
// between tokens and the queue empties.
`default_nettype none
module source_text_tokenizer #(
  parameter int KEYWORD_CHARS = 8,
  parameter int POSITION_BITS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  stt_byte_if.sink   text_i,
  stt_rec_if.source  rec_o
);
  import stt_pkg::*;

  push_t push;
  logic  space;

  stt_lexer #(
    .KEYWORD_CHARS(KEYWORD_CHARS),
    .POSITION_BITS(POSITION_BITS)
  ) u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .text_i (text_i),
    .space_i(space),
    .push_o (push)
  );

  stt_res_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .space_o(space),
    .rec_o  (rec_o)
  );

endmodule
`default_nettype wire
